@@ sv/rqir_pkg.sv @@
package rqir_pkg;

    localparam int IO_DW = 32;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_TRAV   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // memory read address select
    typedef enum logic [2:0] {
        RD_NONE,
        RD_AT,
        RD_HEAD,
        RD_PREV,
        RD_PREV2,
        RD_NEXT
    } t_rd_sel;

    typedef struct packed {
        logic    load_in;
        logic    cfg_wr;
        logic    push;
        logic    clear;
        logic    set_res;
        logic    res_ok;
        logic    take_val;
        logic    shift;
        logic    adv_head;
        logic    emit_trav;
        logic    emit_resp;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       pos_ok;
        logic       trav_zero;
        logic       cnt_zero;
        logic       cnt_one;
        logic       out_free;
    } t_status;

endpackage

@@ sv/rqir_if.sv @@
interface rqir_in_if import rqir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       opcode;
    logic [IO_DW-1:0] write_data;
    logic [3:0]       position;
    logic [3:0]       max_count;

    modport source (output valid, output opcode, output write_data, output position,
                    output max_count, input ready);
    modport sink (input valid, input opcode, input write_data, input position,
                  input max_count, output ready);
endinterface

interface rqir_out_if import rqir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [IO_DW-1:0] read_data;
    logic             last;
    logic [3:0]       item_count;
    logic             is_empty;
    logic             is_full;

    modport source (output valid, output ok, output read_data, output last,
                    output item_count, output is_empty, output is_full, input ready);
    modport sink (input valid, input ok, input read_data, input last,
                  input item_count, input is_empty, input is_full, output ready);
endinterface

interface rqir_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/rqir_ctrl.sv @@
module rqir_ctrl import rqir_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_cfg_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_cfg_ready,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_TRAV  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = RD_NONE;
        o_cmd.cfg_wr = i_cfg_valid && (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                unique case (i_status.op) inside
                    OP_PUSH: begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_ok  = !i_status.full;
                        o_cmd.push    = !i_status.full;
                    end
                    OP_REMOVE, OP_READ: begin
                        if (i_status.pos_ok) begin
                            o_cmd.rd_sel = RD_AT;
                            n_state      = S_FETCH;
                        end else begin
                            o_cmd.set_res = 1'b1;
                        end
                    end
                    OP_TRAV: begin
                        if (i_status.trav_zero) begin
                            o_cmd.set_res = 1'b1;
                        end else begin
                            o_cmd.rd_sel = RD_HEAD;
                            n_state      = S_TRAV;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear   = 1'b1;
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_ok  = 1'b1;
                    end
                    default: begin
                        o_cmd.set_res = 1'b1;
                    end
                endcase
            end
            S_FETCH: begin
                o_cmd.take_val = 1'b1;
                n_state        = S_RESP;
                if (i_status.op == OP_REMOVE) begin
                    if (i_status.cnt_zero) begin
                        o_cmd.adv_head = 1'b1;
                    end else begin
                        o_cmd.rd_sel = RD_PREV;
                        n_state      = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // one word moves toward the rear each cycle
                o_cmd.shift = 1'b1;
                if (i_status.cnt_one) begin
                    o_cmd.adv_head = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.rd_sel = RD_PREV2;
                end
            end
            S_TRAV: begin
                if (i_status.out_free) begin
                    o_cmd.emit_trav = 1'b1;
                    if (i_status.cnt_one) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_sel = RD_NEXT;
                    end
                end
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.emit_resp = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/rqir_dp.sv @@
module rqir_dp import rqir_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [2:0]       i_opcode,
    input  logic [IO_DW-1:0] i_write_data,
    input  logic [3:0]       i_position,
    input  logic [3:0]       i_max_count,
    input  logic [4:0]       i_cfg_data,
    input  logic             i_out_ready,
    output t_status          o_status,
    output logic             o_out_valid,
    output logic             o_out_ok,
    output logic [IO_DW-1:0] o_out_read_data,
    output logic             o_out_last,
    output logic [3:0]       o_out_item_count,
    output logic             o_out_is_empty,
    output logic             o_out_is_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam int CW = (NW > 4) ? NW : 4;
    localparam int AW = CW + 1;
    localparam int LW = (NW > 5) ? NW : 5;

    logic [DATA_WIDTH-1:0] r_slot_store [DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_q;

    logic [4:0]            r_ring_len;
    logic [PW-1:0]         r_head;
    logic [PW-1:0]         r_tail;
    logic [PW-1:0]         r_cur;
    logic [CW-1:0]         r_cnt;
    logic [2:0]            r_op;
    logic [DATA_WIDTH-1:0] r_wdata;
    logic [3:0]            r_pos;
    logic [3:0]            r_maxc;
    logic                  r_ok;
    logic [DATA_WIDTH-1:0] r_val;

    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [IO_DW-1:0]      r_out_data;
    logic                  r_out_last;
    logic [3:0]            r_out_count;
    logic                  r_out_empty;
    logic                  r_out_full;

    logic [NW-1:0]         ring_n;
    logic [NW-1:0]         head_ext;
    logic [NW-1:0]         tail_ext;
    logic [NW-1:0]         used;
    logic                  full;
    logic                  empty;
    logic [AW-1:0]         at_sum;
    logic [PW-1:0]         at_idx;
    logic [CW-1:0]         trav_cnt;
    logic [PW-1:0]         cur_prev;
    logic [PW-1:0]         cur_prev2;
    logic [PW-1:0]         cur_next;
    logic [PW-1:0]         tail_next;
    logic [PW-1:0]         head_next;
    logic                  rd_en;
    logic [PW-1:0]         rd_addr;
    logic                  wr_en;
    logic [PW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  out_free;

    function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] p,
                                               input logic [NW-1:0] n);
        logic [NW-1:0] s;
        s = NW'(p) + NW'(1);
        return (s == n) ? '0 : PW'(s);
    endfunction

    function automatic logic [PW-1:0] prev_idx(input logic [PW-1:0] p,
                                               input logic [NW-1:0] n);
        return (p == '0) ? PW'(n - NW'(1)) : p - PW'(1);
    endfunction

    // ring length is clamped into 2..DEPTH
    always_comb begin
        if (r_ring_len < 5'd2) begin
            ring_n = NW'(2);
        end else if (LW'(r_ring_len) > LW'(DEPTH)) begin
            ring_n = NW'(DEPTH);
        end else begin
            ring_n = NW'(r_ring_len);
        end
    end

    assign head_ext  = NW'(r_head);
    assign tail_ext  = NW'(r_tail);
    assign used      = (tail_ext >= head_ext) ? tail_ext - head_ext
                                              : (ring_n - head_ext) + tail_ext;
    assign tail_next = next_idx(r_tail, ring_n);
    assign head_next = next_idx(r_head, ring_n);
    assign full      = (tail_next == r_head);
    assign empty     = (r_head == r_tail);

    assign at_sum    = AW'(r_head) + AW'(r_pos);
    assign at_idx    = (at_sum >= AW'(ring_n)) ? PW'(at_sum - AW'(ring_n)) : PW'(at_sum);
    assign trav_cnt  = (CW'(used) < CW'(r_maxc)) ? CW'(used) : CW'(r_maxc);

    assign cur_prev  = prev_idx(r_cur, ring_n);
    assign cur_prev2 = prev_idx(cur_prev, ring_n);
    assign cur_next  = next_idx(r_cur, ring_n);

    assign out_free  = !r_out_valid || i_out_ready;

    assign o_status.op        = r_op;
    assign o_status.full      = full;
    assign o_status.pos_ok    = (CW'(r_pos) < CW'(used));
    assign o_status.trav_zero = (trav_cnt == '0);
    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.cnt_one   = (r_cnt == CW'(1));
    assign o_status.out_free  = out_free;

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_cur;
        case (i_cmd.rd_sel)
            RD_AT:    rd_addr = at_idx;
            RD_HEAD:  rd_addr = r_head;
            RD_PREV:  rd_addr = cur_prev;
            RD_PREV2: rd_addr = cur_prev2;
            RD_NEXT:  rd_addr = cur_next;
            default:  rd_en   = 1'b0;
        endcase
    end

    assign wr_en   = i_cmd.push || i_cmd.shift;
    assign wr_addr = i_cmd.push ? r_tail : r_cur;
    assign wr_data = i_cmd.push ? r_wdata : r_mem_q;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_slot_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_len  <= 5'd16;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_wr) begin
                r_ring_len <= i_cfg_data;
                r_head     <= '0;
                r_tail     <= '0;
            end else if (i_cmd.clear) begin
                r_head <= '0;
                r_tail <= '0;
            end else begin
                if (i_cmd.push) begin
                    r_tail <= tail_next;
                end
                if (i_cmd.adv_head) begin
                    r_head <= head_next;
                end
            end
            if (i_cmd.emit_trav || i_cmd.emit_resp) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_opcode;
            r_wdata <= DATA_WIDTH'(i_write_data);
            r_pos   <= i_position;
            r_maxc  <= i_max_count;
        end
        if (i_cmd.rd_sel == RD_AT) begin
            r_cur <= at_idx;
            r_cnt <= CW'(r_pos);
        end else if (i_cmd.rd_sel == RD_HEAD) begin
            r_cur <= r_head;
            r_cnt <= trav_cnt;
        end else if (i_cmd.shift) begin
            r_cur <= cur_prev;
            r_cnt <= r_cnt - CW'(1);
        end else if (i_cmd.emit_trav) begin
            r_cur <= cur_next;
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.set_res) begin
            r_ok  <= i_cmd.res_ok;
            r_val <= '0;
        end else if (i_cmd.take_val) begin
            r_ok  <= 1'b1;
            r_val <= r_mem_q;
        end
        if (i_cmd.emit_trav || i_cmd.emit_resp) begin
            r_out_ok    <= i_cmd.emit_trav ? 1'b1 : r_ok;
            r_out_data  <= i_cmd.emit_trav ? IO_DW'(r_mem_q) : IO_DW'(r_val);
            r_out_last  <= i_cmd.emit_trav ? (r_cnt == CW'(1)) : 1'b1;
            r_out_count <= 4'(used);
            r_out_empty <= empty;
            r_out_full  <= full;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_ok         = r_out_ok;
    assign o_out_read_data  = r_out_data;
    assign o_out_last       = r_out_last;
    assign o_out_item_count = r_out_count;
    assign o_out_is_empty   = r_out_empty;
    assign o_out_is_full    = r_out_full;

endmodule

@@ sv/ring_queue_with_indexed_remove.sv @@
// states from accepted word to result: push, clear, rejects exec, resp; read exec,
// fetch, resp; remove adds the shift loop if position is nonzero; traverse exec, then
// one word per cycle unless results stall; next word taken once the last result is
// emitted; remove time is set by the shift loop over slot memory, one slot per cycle
// reset: head and tail to zero, ring_length to 16, result register empty
// slot contents are undefined after reset and only ever read after being written
module ring_queue_with_indexed_remove import rqir_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rqir_in_if.sink   i_in,
    rqir_out_if.source o_out,
    rqir_cfg_if.sink  i_cfg
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    cfg_ready;

    rqir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_cfg_valid (i_cfg.valid),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_cfg_ready (cfg_ready),
        .o_cmd       (cmd)
    );

    rqir_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (i_in.opcode),
        .i_write_data     (i_in.write_data),
        .i_position       (i_in.position),
        .i_max_count      (i_in.max_count),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_out.ready),
        .o_status         (status),
        .o_out_valid      (o_out.valid),
        .o_out_ok         (o_out.ok),
        .o_out_read_data  (o_out.read_data),
        .o_out_last       (o_out.last),
        .o_out_item_count (o_out.item_count),
        .o_out_is_empty   (o_out.is_empty),
        .o_out_is_full    (o_out.is_full)
    );

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = cfg_ready;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again right after a word was accepted");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_empty) |-> (o_out.item_count == 4'd0 && !o_out.is_full))
        else $error("empty result with nonzero count or full flag");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ok) |-> (o_out.read_data == '0 && o_out.last))
        else $error("failed result carries data or is not last");

    a_traverse_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> !i_in.ready)
        else $error("input accepted while a traverse is still emitting");
`endif

endmodule

@@ tb/ring_queue_with_indexed_remove_tb.sv @@
module ring_queue_with_indexed_remove_tb;
    import rqir_pkg::*;

    localparam int          SLOTS         = 16;
    localparam int          SETTLE_CYCLES = 30;
    localparam int          LONG_STALL    = 400;
    localparam int          PHASES        = 12;
    localparam int          PHASE_WORDS   = 40;
    localparam logic [2:0]  OP_RSVD5      = 3'd5;
    localparam logic [2:0]  OP_RSVD6      = 3'd6;
    localparam logic [2:0]  OP_RSVD7      = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] write_data;
        logic [3:0]  position;
        logic [3:0]  max_count;
    } in_word_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_data;
        logic        last;
        logic [3:0]  item_count;
        logic        is_empty;
        logic        is_full;
    } out_word_t;

    typedef enum logic [1:0] {ROW_OPEN, ROW_TYPED, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        in_word_t   word;
        out_word_t  want;
        logic [4:0] ring_len;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rqir_in_if  in_if ();
    rqir_out_if out_if ();
    rqir_cfg_if cfg_if ();

    ring_queue_with_indexed_remove dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the ring
    logic [31:0] slot_copy [0:SLOTS-1];
    int unsigned head_copy;
    int unsigned tail_copy;
    logic [4:0]  ring_len_copy;

    out_word_t   expected_words [$];
    stim_row_t   dir_rows [$];
    logic [4:0]  ring_plan [0:PHASES-1] = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd17,
                                           5'd5, 5'd16, 5'd3, 5'd9, 5'd15, 5'd2};

    int burst_left;
    int sink_stall_requests;
    int mismatches;
    int words_checked;
    int items_sent;
    int cfg_writes;
    int full_rejects;
    int multi_traversals;
    int shifted_removes;

    function automatic int unsigned ring_slots();
        if (ring_len_copy < 5'd2) return 2;
        if (ring_len_copy > 5'(SLOTS)) return SLOTS;
        return 32'(ring_len_copy);
    endfunction

    function automatic int unsigned fill_level();
        return (tail_copy + ring_slots() - head_copy) % ring_slots();
    endfunction

    function automatic out_word_t status_word(logic ok, logic [31:0] data, logic last);
        out_word_t s;
        s.ok         = ok;
        s.read_data  = data;
        s.last       = last;
        s.item_count = 4'(fill_level());
        s.is_empty   = (head_copy == tail_copy);
        s.is_full    = (((tail_copy + 1) % ring_slots()) == head_copy);
        return s;
    endfunction

    function automatic void apply_ring_length(logic [4:0] v);
        ring_len_copy = v;
        head_copy     = 0;
        tail_copy     = 0;
    endfunction

    function automatic void apply_queue_op(in_word_t w);
        int unsigned n;
        int unsigned used;
        int unsigned at;
        int unsigned prev;
        int unsigned cnt;
        int unsigned k;
        logic [31:0] val;
        n    = ring_slots();
        used = fill_level();
        case (w.opcode)
            OP_PUSH: begin
                if (((tail_copy + 1) % n) == head_copy) begin
                    full_rejects++;
                    expected_words.push_back(status_word(1'b0, 32'd0, 1'b1));
                end else begin
                    slot_copy[4'(tail_copy)] = w.write_data;
                    tail_copy = (tail_copy + 1) % n;
                    expected_words.push_back(status_word(1'b1, 32'd0, 1'b1));
                end
            end
            OP_REMOVE, OP_READ: begin
                if (used == 0 || 32'(w.position) >= used) begin
                    expected_words.push_back(status_word(1'b0, 32'd0, 1'b1));
                end else begin
                    at  = (head_copy + 32'(w.position)) % n;
                    val = slot_copy[4'(at)];
                    if (w.opcode == OP_REMOVE) begin
                        // words ahead of the removed one slide back by one slot
                        for (k = 32'(w.position); k > 0; k--) begin
                            prev = (at == 0) ? n - 1 : at - 1;
                            slot_copy[4'(at)] = slot_copy[4'(prev)];
                            at = prev;
                        end
                        if (w.position != 4'd0) shifted_removes++;
                        head_copy = (head_copy + 1) % n;
                    end
                    expected_words.push_back(status_word(1'b1, val, 1'b1));
                end
            end
            OP_TRAV: begin
                cnt = (used < 32'(w.max_count)) ? used : 32'(w.max_count);
                at  = head_copy;
                if (cnt == 0) begin
                    expected_words.push_back(status_word(1'b0, 32'd0, 1'b1));
                end else begin
                    if (cnt > 1) multi_traversals++;
                    for (k = 0; k < cnt; k++) begin
                        expected_words.push_back(status_word(1'b1, slot_copy[4'(at)],
                                                             k + 1 == cnt));
                        at = (at + 1) % n;
                    end
                end
            end
            OP_CLEAR: begin
                for (k = 0; k < SLOTS; k++) slot_copy[4'(k)] = 32'd0;
                head_copy = 0;
                tail_copy = 0;
                expected_words.push_back(status_word(1'b1, 32'd0, 1'b1));
            end
            default: begin
                expected_words.push_back(status_word(1'b0, 32'd0, 1'b1));
            end
        endcase
    endfunction

    function automatic in_word_t random_word(int push_pct);
        in_word_t w;
        int unsigned used;
        int r;
        used         = fill_level();
        w.write_data = $urandom;
        w.position   = 4'($urandom_range(0, 15));
        w.max_count  = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            w.opcode = OP_PUSH;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 38)      w.opcode = OP_REMOVE;
            else if (r < 66) w.opcode = OP_READ;
            else if (r < 93) w.opcode = OP_TRAV;
            else if (r < 96) w.opcode = OP_CLEAR;
            else             w.opcode = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        end
        // mostly legal positions so removes and reads actually hit stored words
        if (used != 0 && $urandom_range(0, 99) < 85)
            w.position = 4'($urandom_range(0, used - 1));
        return w;
    endfunction

    function automatic void open_row(logic [2:0] op, logic [31:0] d, logic [3:0] p,
                                     logic [3:0] m);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_OPEN;
        row.word = '{op, d, p, m};
        dir_rows.push_back(row);
    endfunction

    function automatic void typed_row(logic [2:0] op, logic [31:0] d, logic [3:0] p,
                                      logic [3:0] m, logic ok, logic [31:0] rd,
                                      logic [3:0] cnt, logic e, logic f);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_TYPED;
        row.word = '{op, d, p, m};
        row.want = '{ok, rd, 1'b1, cnt, e, f};
        dir_rows.push_back(row);
    endfunction

    function automatic void cfg_row(logic [4:0] v);
        stim_row_t row;
        row          = '0;
        row.kind     = ROW_CFG;
        row.ring_len = v;
        dir_rows.push_back(row);
    endfunction

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        int gap;
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        in_if.valid      <= 1'b1;
        in_if.opcode     <= w.opcode;
        in_if.write_data <= w.write_data;
        in_if.position   <= w.position;
        in_if.max_count  <= w.max_count;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        burst_left--;
        items_sent++;
        apply_queue_op(w);
        if (typed) begin
            void'(expected_words.pop_back());
            expected_words.push_back(want);
        end
    endtask

    task automatic drain_and_settle();
        in_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ring_length(input logic [4:0] v);
        drain_and_settle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        apply_ring_length(v);
        cfg_writes++;
    endtask

    function automatic void check_field(string name, int idx, logic [31:0] want,
                                        logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d: %s expected %h, got %h", idx, name, want, got);
        end
    endfunction

    // result checker
    initial begin
        out_word_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: unexpected result word, read_data %h",
                                 words_checked, out_if.read_data);
                end else begin
                    want = expected_words.pop_front();
                    check_field("ok", words_checked, 32'(want.ok), 32'(out_if.ok));
                    check_field("read_data", words_checked, want.read_data,
                                out_if.read_data);
                    check_field("last", words_checked, 32'(want.last), 32'(out_if.last));
                    check_field("item_count", words_checked, 32'(want.item_count),
                                32'(out_if.item_count));
                    check_field("is_empty", words_checked, 32'(want.is_empty),
                                32'(out_if.is_empty));
                    check_field("is_full", words_checked, 32'(want.is_full),
                                32'(out_if.is_full));
                end
                words_checked++;
            end
        end
    end

    // result side ready pattern, with one long hold-off
    initial begin
        int unsigned cyc;
        int unsigned hold;
        int          stalls_served;
        logic [7:0]  pat;
        cyc           = 0;
        hold          = 0;
        stalls_served = 0;
        pat           = 8'b1011_0010;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (stalls_served != sink_stall_requests) begin
                stalls_served = sink_stall_requests;
                hold = LONG_STALL;
            end
            if (hold != 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else begin
                case ((cyc / 150) % 4)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= ($urandom_range(0, 3) != 0);
                    2:       out_if.ready <= pat[3'(cyc % 8)];
                    default: out_if.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int row_idx;
        int phase;
        int k;
        int push_pct;
        stim_row_t row;

        burst_left          = 0;
        sink_stall_requests = 0;
        mismatches          = 0;
        words_checked       = 0;
        items_sent          = 0;
        cfg_writes          = 0;
        full_rejects        = 0;
        multi_traversals    = 0;
        shifted_removes     = 0;
        head_copy           = 0;
        tail_copy           = 0;
        ring_len_copy       = 5'd16;

        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.opcode     <= OP_PUSH;
        in_if.write_data <= 32'd0;
        in_if.position   <= 4'd0;
        in_if.max_count  <= 4'd0;
        cfg_if.valid     <= 1'b0;
        cfg_if.data      <= 5'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        //        opcode     write_data     pos    max    ok    read_data      cnt    emp   full
        typed_row(OP_REMOVE, 32'd0,         4'd0,  4'd0,  1'b0, 32'd0,         4'd0,  1'b1, 1'b0);
        typed_row(OP_READ,   32'd0,         4'd15, 4'd0,  1'b0, 32'd0,         4'd0,  1'b1, 1'b0);
        typed_row(OP_TRAV,   32'd0,         4'd0,  4'd15, 1'b0, 32'd0,         4'd0,  1'b1, 1'b0);
        typed_row(OP_PUSH,   32'hFFFF_FFFF, 4'd0,  4'd0,  1'b1, 32'd0,         4'd1,  1'b0, 1'b0);
        typed_row(OP_PUSH,   32'h0000_0000, 4'd15, 4'd15, 1'b1, 32'd0,         4'd2,  1'b0, 1'b0);
        typed_row(OP_PUSH,   32'hA5A5_A5A5, 4'd0,  4'd0,  1'b1, 32'd0,         4'd3,  1'b0, 1'b0);
        typed_row(OP_READ,   32'd0,         4'd0,  4'd0,  1'b1, 32'hFFFF_FFFF, 4'd3,  1'b0, 1'b0);
        typed_row(OP_READ,   32'd0,         4'd2,  4'd0,  1'b1, 32'hA5A5_A5A5, 4'd3,  1'b0, 1'b0);
        // position equal to the count is out of range
        typed_row(OP_READ,   32'd0,         4'd3,  4'd0,  1'b0, 32'd0,         4'd3,  1'b0, 1'b0);
        typed_row(OP_TRAV,   32'd0,         4'd0,  4'd0,  1'b0, 32'd0,         4'd3,  1'b0, 1'b0);
        open_row(OP_TRAV,    32'd0,         4'd0,  4'd15);
        open_row(OP_TRAV,    32'd0,         4'd0,  4'd2);
        open_row(OP_REMOVE,  32'd0,         4'd2,  4'd0);
        open_row(OP_REMOVE,  32'd0,         4'd1,  4'd0);
        typed_row(OP_RSVD5,  32'h5555_5555, 4'd15, 4'd15, 1'b0, 32'd0,         4'd1,  1'b0, 1'b0);
        typed_row(OP_RSVD6,  32'hAAAA_AAAA, 4'd0,  4'd0,  1'b0, 32'd0,         4'd1,  1'b0, 1'b0);
        typed_row(OP_RSVD7,  32'hFFFF_FFFF, 4'd15, 4'd15, 1'b0, 32'd0,         4'd1,  1'b0, 1'b0);
        typed_row(OP_CLEAR,  32'd0,         4'd0,  4'd0,  1'b1, 32'd0,         4'd0,  1'b1, 1'b0);
        typed_row(OP_REMOVE, 32'd0,         4'd0,  4'd0,  1'b0, 32'd0,         4'd0,  1'b1, 1'b0);
        cfg_row(5'd2);
        typed_row(OP_PUSH,   32'h1234_5678, 4'd0,  4'd0,  1'b1, 32'd0,         4'd1,  1'b0, 1'b1);
        typed_row(OP_PUSH,   32'h0000_0001, 4'd0,  4'd0,  1'b0, 32'd0,         4'd1,  1'b0, 1'b1);
        typed_row(OP_REMOVE, 32'd0,         4'd1,  4'd0,  1'b0, 32'd0,         4'd1,  1'b0, 1'b1);
        typed_row(OP_READ,   32'd0,         4'd0,  4'd0,  1'b1, 32'h1234_5678, 4'd1,  1'b0, 1'b1);
        typed_row(OP_REMOVE, 32'd0,         4'd0,  4'd0,  1'b1, 32'h1234_5678, 4'd0,  1'b1, 1'b0);

        for (row_idx = 0; row_idx < dir_rows.size(); row_idx++) begin
            row = dir_rows[row_idx];
            if (row.kind == ROW_CFG)
                write_ring_length(row.ring_len);
            else
                send_word(row.word, row.kind == ROW_TYPED, row.want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            write_ring_length(ring_plan[4'(phase)]);
            // sink holds off while words keep coming, so the input backs up
            if (phase == 0) sink_stall_requests++;
            push_pct = (phase % 2 == 0) ? 65 : 35;
            for (k = 0; k < PHASE_WORDS; k++) begin
                if (phase == 6 && k == PHASE_WORDS / 2) drain_and_settle();
                send_word(random_word(push_pct), 1'b0, '0);
            end
        end

        drain_and_settle();
        $display("ran %0d queue operations over %0d ring length writes, %0d result words",
                 items_sent, cfg_writes, words_checked);
        $display("including %0d full pushes, %0d shifting removes, %0d multi-word traversals",
                 full_rejects, shifted_removes, multi_traversals);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
